// File: design/stla_pkg.sv
// shared types and constants for the session table with lru aging
package stla_pkg;

	localparam int KEY_BITS    = 48;
	localparam int BUCKET_BITS = 7;
	localparam int BUCKETS     = 128;

	typedef enum logic [2:0] {
		ACT_LOOKUP = 3'd0,
		ACT_CREATE = 3'd1,
		ACT_TOUCH  = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_REAP   = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_DONE     = 3'd0,
		ST_MISS     = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOT_USED = 3'd3,
		ST_EXPIRED  = 3'd4,
		ST_NONE_EXP = 3'd5
	} status_t;

	typedef struct packed {
		logic [2:0]          action;
		logic [KEY_BITS-1:0] flow_key;
		logic [5:0]          slot_index;
		logic [31:0]         now_seconds;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [5:0]          result_slot;
		logic [KEY_BITS-1:0] result_key;
		logic                last_result;
	} out_item_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_START,
		FSM_LK_HEAD,
		FSM_LK_WALK,
		FSM_CR_LINK,
		FSM_UNLINK,
		FSM_PUSH_A,
		FSM_PUSH_B,
		FSM_FR_HEAD,
		FSM_FR_WALK,
		FSM_FR_END,
		FSM_RP_TAIL,
		FSM_RP_TEST
	} fsm_t;

endpackage

// File: design/session_table_lru_aging_unit.sv
// session table with hashed key chains, free stack, recency list and timeout reaping
// throughput: one item at a time, busy high until its last result is issued
// results come out of a register in the cycle after the deciding cycle; receiver cannot stall
// reset clears control, live flags and valid flags; chain links and bucket heads read as
// their reset values until first written, so no clearing pass is needed
module session_table_lru_aging_unit #(
	parameter int SLOTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  stla_pkg::in_item_t   cmd,
	output logic                 busy,
	output logic                 res_valid,
	output stla_pkg::out_item_t  res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);

	// pointer width holds the slot range plus the nil code
	localparam int PW = $clog2(SLOTS + 1);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [PW-1:0] NIL = PW'(SLOTS);
	localparam int KB = stla_pkg::KEY_BITS;
	localparam int BB = stla_pkg::BUCKET_BITS;

	typedef logic [PW-1:0] ptr_t;

	function automatic logic [SW-1:0] ix(input ptr_t p);
		return p[SW-1:0];
	endfunction

	function automatic logic [5:0] to_slot(input ptr_t p);
		logic [6:0] w;
		w = 7'(p);
		return w[5:0];
	endfunction

	// storage
	logic [KB-1:0] key_mem   [SLOTS];
	logic [31:0]   time_mem  [SLOTS];
	ptr_t          rprev_mem [SLOTS];
	ptr_t          rnext_mem [SLOTS];
	ptr_t          chain_mem [SLOTS];
	ptr_t          bhead_mem [stla_pkg::BUCKETS];
	logic          chain_vld [SLOTS];
	logic          bhead_vld [stla_pkg::BUCKETS];
	logic          live_q    [SLOTS];

	// registered read data
	logic [KB-1:0] key_rd_q;
	logic [31:0]   time_rd_q;
	ptr_t          rprev_rd_q, rnext_rd_q, chain_rd_q, bhead_rd_q;
	logic          live_rd_q;

	// read ports
	logic          key_re, time_re, rl_re, chain_re, bh_re;
	logic [SW-1:0] key_ra, time_ra, rl_ra, chain_ra;
	logic [BB-1:0] bh_ra;

	// write ports
	logic          key_we, time_we, rprev_we, rnext_we, chain_we, bh_we;
	logic          live_set, live_clr;
	logic [SW-1:0] key_wa, time_wa, rprev_wa, rnext_wa, chain_wa, live_wa;
	logic [BB-1:0] bh_wa;
	logic [KB-1:0] key_wd;
	logic [31:0]   time_wd;
	ptr_t          rprev_wd, rnext_wd, chain_wd, bh_wd;

	// control
	stla_pkg::fsm_t state_q, state_d;
	logic [2:0]     act_q;
	logic [KB-1:0]  key_q;
	logic [5:0]     sidx_q;
	logic [31:0]    now_q;
	logic [15:0]    timeout_q;
	ptr_t           s_q, s_d, cur_q, cur_d, prev_q, prev_d;
	ptr_t           head_q, head_d, tail_q, tail_d, free_q, free_d;
	logic           any_q, any_d;
	ptr_t           pend_slot_q, pend_slot_d;
	logic [KB-1:0]  pend_key_q, pend_key_d;

	logic           emit;
	stla_pkg::out_item_t emit_item;
	logic           accept;
	logic           expired;
	logic [BB-1:0]  own_bucket;

	assign busy      = (state_q != stla_pkg::FSM_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = !busy;

	// expiry test carried one bit wider so the sum never wraps
	assign expired = ({1'b0, time_rd_q} + {17'b0, timeout_q}) <= {1'b0, now_q};
	// bucket of the slot being freed
	assign own_bucket = key_rd_q[BB-1:0];

	always_comb begin
		state_d     = state_q;
		s_d         = s_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		head_d      = head_q;
		tail_d      = tail_q;
		free_d      = free_q;
		any_d       = any_q;
		pend_slot_d = pend_slot_q;
		pend_key_d  = pend_key_q;

		key_re = 1'b0;  key_ra = '0;
		time_re = 1'b0; time_ra = '0;
		rl_re = 1'b0;   rl_ra = '0;
		chain_re = 1'b0; chain_ra = '0;
		bh_re = 1'b0;   bh_ra = '0;

		key_we = 1'b0;   key_wa = '0;   key_wd = key_q;
		time_we = 1'b0;  time_wa = '0;  time_wd = now_q;
		rprev_we = 1'b0; rprev_wa = '0; rprev_wd = NIL;
		rnext_we = 1'b0; rnext_wa = '0; rnext_wd = NIL;
		chain_we = 1'b0; chain_wa = '0; chain_wd = NIL;
		bh_we = 1'b0;    bh_wa = '0;    bh_wd = NIL;
		live_set = 1'b0; live_clr = 1'b0; live_wa = '0;

		emit      = 1'b0;
		emit_item = '{status: 3'(stla_pkg::ST_MISS), result_slot: 6'd0,
			result_key: '0, last_result: 1'b1};

		case (state_q)
			stla_pkg::FSM_IDLE: begin
				if (accept) state_d = stla_pkg::FSM_START;
			end

			stla_pkg::FSM_START: begin
				case (act_q)
					3'(stla_pkg::ACT_LOOKUP): begin
						bh_re   = 1'b1;
						bh_ra   = key_q[BB-1:0];
						state_d = stla_pkg::FSM_LK_HEAD;
					end
					3'(stla_pkg::ACT_CREATE): begin
						if (free_q == NIL) begin
							emit = 1'b1;
							emit_item.status = 3'(stla_pkg::ST_FULL);
							state_d = stla_pkg::FSM_IDLE;
						end else begin
							s_d      = free_q;
							key_we   = 1'b1; key_wa = ix(free_q);
							time_we  = 1'b1; time_wa = ix(free_q);
							live_set = 1'b1; live_wa = ix(free_q);
							chain_re = 1'b1; chain_ra = ix(free_q);
							bh_re    = 1'b1; bh_ra = key_q[BB-1:0];
							state_d  = stla_pkg::FSM_CR_LINK;
						end
					end
					3'(stla_pkg::ACT_TOUCH), 3'(stla_pkg::ACT_REMOVE): begin
						if ((7'(sidx_q) >= 7'(SLOTS)) || !live_rd_q) begin
							emit = 1'b1;
							emit_item.status      = 3'(stla_pkg::ST_NOT_USED);
							emit_item.result_slot = sidx_q;
							state_d = stla_pkg::FSM_IDLE;
						end else begin
							s_d     = PW'(sidx_q[SW-1:0]);
							key_re  = 1'b1; key_ra = sidx_q[SW-1:0];
							rl_re   = 1'b1; rl_ra = sidx_q[SW-1:0];
							state_d = stla_pkg::FSM_UNLINK;
						end
					end
					3'(stla_pkg::ACT_REAP): begin
						any_d   = 1'b0;
						state_d = stla_pkg::FSM_RP_TAIL;
					end
					default: begin
						emit    = 1'b1;
						state_d = stla_pkg::FSM_IDLE;
					end
				endcase
			end

			// lookup walks the bucket chain, newest first
			stla_pkg::FSM_LK_HEAD: begin
				if (bhead_rd_q == NIL) begin
					emit    = 1'b1;
					state_d = stla_pkg::FSM_IDLE;
				end else begin
					cur_d    = bhead_rd_q;
					key_re   = 1'b1; key_ra = ix(bhead_rd_q);
					chain_re = 1'b1; chain_ra = ix(bhead_rd_q);
					state_d  = stla_pkg::FSM_LK_WALK;
				end
			end

			stla_pkg::FSM_LK_WALK: begin
				if (key_rd_q == key_q) begin
					emit = 1'b1;
					emit_item.status      = 3'(stla_pkg::ST_DONE);
					emit_item.result_slot = to_slot(cur_q);
					emit_item.result_key  = key_q;
					state_d = stla_pkg::FSM_IDLE;
				end else if (chain_rd_q == NIL) begin
					emit    = 1'b1;
					state_d = stla_pkg::FSM_IDLE;
				end else begin
					cur_d    = chain_rd_q;
					key_re   = 1'b1; key_ra = ix(chain_rd_q);
					chain_re = 1'b1; chain_ra = ix(chain_rd_q);
				end
			end

			// pop the free stack and put the slot at the head of its bucket
			stla_pkg::FSM_CR_LINK: begin
				free_d   = chain_rd_q;
				chain_we = 1'b1; chain_wa = ix(s_q); chain_wd = bhead_rd_q;
				bh_we    = 1'b1; bh_wa = key_q[BB-1:0]; bh_wd = s_q;
				state_d  = stla_pkg::FSM_PUSH_A;
			end

			// take the slot out of the recency list
			stla_pkg::FSM_UNLINK: begin
				if (rprev_rd_q != NIL) begin
					rnext_we = 1'b1; rnext_wa = ix(rprev_rd_q); rnext_wd = rnext_rd_q;
				end else begin
					head_d = rnext_rd_q;
				end
				if (rnext_rd_q != NIL) begin
					rprev_we = 1'b1; rprev_wa = ix(rnext_rd_q); rprev_wd = rprev_rd_q;
				end else begin
					tail_d = rprev_rd_q;
				end
				if (act_q == 3'(stla_pkg::ACT_TOUCH)) begin
					time_we = 1'b1; time_wa = ix(s_q);
					state_d = stla_pkg::FSM_PUSH_A;
				end else begin
					prev_d  = NIL;
					bh_re   = 1'b1; bh_ra = own_bucket;
					state_d = stla_pkg::FSM_FR_HEAD;
				end
			end

			// make the slot most recent
			stla_pkg::FSM_PUSH_A: begin
				rprev_we = 1'b1; rprev_wa = ix(s_q); rprev_wd = NIL;
				rnext_we = 1'b1; rnext_wa = ix(s_q); rnext_wd = head_q;
				state_d  = stla_pkg::FSM_PUSH_B;
			end

			stla_pkg::FSM_PUSH_B: begin
				if (head_q != NIL) begin
					rprev_we = 1'b1; rprev_wa = ix(head_q); rprev_wd = s_q;
				end else begin
					tail_d = s_q;
				end
				head_d = s_q;
				emit   = 1'b1;
				emit_item.status      = 3'(stla_pkg::ST_DONE);
				emit_item.result_slot = to_slot(s_q);
				emit_item.result_key  = (act_q == 3'(stla_pkg::ACT_CREATE)) ? key_q : key_rd_q;
				state_d = stla_pkg::FSM_IDLE;
			end

			// free: find the slot in its bucket chain and splice it out
			stla_pkg::FSM_FR_HEAD: begin
				cur_d = bhead_rd_q;
				if (bhead_rd_q == NIL) begin
					state_d = stla_pkg::FSM_FR_END;
				end else begin
					chain_re = 1'b1; chain_ra = ix(bhead_rd_q);
					state_d  = stla_pkg::FSM_FR_WALK;
				end
			end

			stla_pkg::FSM_FR_WALK: begin
				if (cur_q == s_q) begin
					if (prev_q == NIL) begin
						bh_we = 1'b1; bh_wa = own_bucket; bh_wd = chain_rd_q;
					end else begin
						chain_we = 1'b1; chain_wa = ix(prev_q); chain_wd = chain_rd_q;
					end
					state_d = stla_pkg::FSM_FR_END;
				end else if (chain_rd_q == NIL) begin
					state_d = stla_pkg::FSM_FR_END;
				end else begin
					prev_d   = cur_q;
					cur_d    = chain_rd_q;
					chain_re = 1'b1; chain_ra = ix(chain_rd_q);
				end
			end

			// push the slot on the free stack
			stla_pkg::FSM_FR_END: begin
				live_clr = 1'b1; live_wa = ix(s_q);
				chain_we = 1'b1; chain_wa = ix(s_q); chain_wd = free_q;
				free_d   = s_q;
				if (act_q == 3'(stla_pkg::ACT_REMOVE)) begin
					emit = 1'b1;
					emit_item.status      = 3'(stla_pkg::ST_DONE);
					emit_item.result_slot = to_slot(s_q);
					emit_item.result_key  = key_rd_q;
					state_d = stla_pkg::FSM_IDLE;
				end else begin
					state_d = stla_pkg::FSM_RP_TAIL;
				end
			end

			// reap: look at the least recent slot
			stla_pkg::FSM_RP_TAIL: begin
				if (tail_q == NIL) begin
					emit = 1'b1;
					if (any_q) begin
						emit_item.status      = 3'(stla_pkg::ST_EXPIRED);
						emit_item.result_slot = to_slot(pend_slot_q);
						emit_item.result_key  = pend_key_q;
					end else begin
						emit_item.status = 3'(stla_pkg::ST_NONE_EXP);
					end
					state_d = stla_pkg::FSM_IDLE;
				end else begin
					s_d     = tail_q;
					key_re  = 1'b1; key_ra = ix(tail_q);
					time_re = 1'b1; time_ra = ix(tail_q);
					rl_re   = 1'b1; rl_ra = ix(tail_q);
					state_d = stla_pkg::FSM_RP_TEST;
				end
			end

			// a held result goes out once it is known whether another follows
			stla_pkg::FSM_RP_TEST: begin
				if (expired) begin
					if (any_q) begin
						emit = 1'b1;
						emit_item.status      = 3'(stla_pkg::ST_EXPIRED);
						emit_item.result_slot = to_slot(pend_slot_q);
						emit_item.result_key  = pend_key_q;
						emit_item.last_result = 1'b0;
					end
					any_d       = 1'b1;
					pend_slot_d = s_q;
					pend_key_d  = key_rd_q;
					state_d     = stla_pkg::FSM_UNLINK;
				end else begin
					emit = 1'b1;
					if (any_q) begin
						emit_item.status      = 3'(stla_pkg::ST_EXPIRED);
						emit_item.result_slot = to_slot(pend_slot_q);
						emit_item.result_key  = pend_key_q;
					end else begin
						emit_item.status = 3'(stla_pkg::ST_NONE_EXP);
					end
					state_d = stla_pkg::FSM_IDLE;
				end
			end

			default: begin
				state_d = stla_pkg::FSM_IDLE;
			end
		endcase
	end

	// memories and their registered read data
	always_ff @(posedge clk) begin
		if (key_we)   key_mem[key_wa]     <= key_wd;
		if (time_we)  time_mem[time_wa]   <= time_wd;
		if (rprev_we) rprev_mem[rprev_wa] <= rprev_wd;
		if (rnext_we) rnext_mem[rnext_wa] <= rnext_wd;
		if (chain_we) chain_mem[chain_wa] <= chain_wd;
		if (bh_we)    bhead_mem[bh_wa]    <= bh_wd;

		if (key_re)  key_rd_q  <= key_mem[key_ra];
		if (time_re) time_rd_q <= time_mem[time_ra];
		if (rl_re) begin
			rprev_rd_q <= rprev_mem[rl_ra];
			rnext_rd_q <= rnext_mem[rl_ra];
		end
		// unwritten chain links read as the initial free stack order
		if (chain_re) begin
			if (chain_vld[chain_ra])
				chain_rd_q <= chain_mem[chain_ra];
			else if (chain_ra == '0)
				chain_rd_q <= NIL;
			else
				chain_rd_q <= PW'(chain_ra) - PW'(1);
		end
		// unwritten bucket heads read as empty
		if (bh_re) bhead_rd_q <= bhead_vld[bh_ra] ? bhead_mem[bh_ra] : NIL;
	end

	// input capture and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= cmd.action;
			key_q     <= cmd.flow_key;
			sidx_q    <= cmd.slot_index;
			now_q     <= cmd.now_seconds;
			// live flags only change while busy, so this read is current in the start cycle
			live_rd_q <= live_q[cmd.slot_index[SW-1:0]];
		end
		s_q         <= s_d;
		cur_q       <= cur_d;
		prev_q      <= prev_d;
		pend_slot_q <= pend_slot_d;
		pend_key_q  <= pend_key_d;
		if (emit) res <= emit_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= stla_pkg::FSM_IDLE;
			head_q    <= NIL;
			tail_q    <= NIL;
			free_q    <= PW'(SLOTS - 1);
			any_q     <= 1'b0;
			res_valid <= 1'b0;
			timeout_q <= 16'd60;
			for (int i = 0; i < SLOTS; i++) begin
				chain_vld[i] <= 1'b0;
				live_q[i]    <= 1'b0;
			end
			for (int i = 0; i < stla_pkg::BUCKETS; i++) bhead_vld[i] <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			free_q    <= free_d;
			any_q     <= any_d;
			res_valid <= emit;
			if (cfg_valid && cfg_ready) timeout_q <= cfg_data;
			if (chain_we) chain_vld[chain_wa] <= 1'b1;
			if (bh_we)    bhead_vld[bh_wa]    <= 1'b1;
			if (live_set) live_q[live_wa] <= 1'b1;
			if (live_clr) live_q[live_wa] <= 1'b0;
		end
	end

endmodule
